// ===== sv/brbuf_pkg.sv =====
package brbuf_pkg;

  // Width of the capacity register and of the fill level
  localparam int unsigned CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Configuration port: one register, word index taken from paddr[2]
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    CMD_READ      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_OVERWRITE = 2'd2,
    CMD_FLUSH     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FILL_EMPTY   = 2'd0,
    FILL_PARTIAL = 2'd1,
    FILL_FULL    = 2'd2
  } fill_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             data_out_valid;
    logic             accepted;
    logic [CAP_W-1:0] fill_level;
    logic [1:0]       fill_status;
  } out_word_t;

  // What the controller knows of a word before the store answers
  typedef struct packed {
    logic             rd;
    logic             acc;
    logic [CAP_W-1:0] level;
    logic [1:0]       status;
  } res_info_t;

endpackage

// ===== sv/brbuf_ram.sv =====
module brbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and a write to one entry in the same cycle return the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/brbuf_cfg.sv =====
module brbuf_cfg #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brbuf_pkg::APB_AW-1:0]  paddr,
  input  logic [brbuf_pkg::APB_DW-1:0]  pwdata,
  output logic [brbuf_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output logic                          cfg_wr_o,
  output logic [$clog2(DEPTH):0]        cap_eff_o
);

  import brbuf_pkg::*;

  localparam int CntW   = $clog2(DEPTH) + 1;
  localparam int CmpW   = (CntW > int'(CAP_W)) ? CntW : int'(CAP_W);
  localparam int CapRst = (DEPTH < int'(CAP_RESET)) ? DEPTH : int'(CAP_RESET);

  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CntW-1:0]  eff_q, eff_d;
  logic             hit;

  assign pready   = 1'b1;
  assign hit      = (paddr[2] == REG_CAPACITY);
  assign cfg_wr_o = psel & penable & pwrite & hit;

  // Clamp to 1..DEPTH once, at write time
  always_comb begin
    cap_d = pwdata[CAP_W-1:0];
    if (cap_d == '0) begin
      eff_d = CntW'(1);
    end else if (CmpW'(cap_d) > CmpW'(DEPTH)) begin
      eff_d = CntW'(DEPTH);
    end else begin
      eff_d = CntW'(cap_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      eff_q <= CntW'(CapRst);
    end else if (cfg_wr_o) begin
      cap_q <= cap_d;
      eff_q <= eff_d;
    end
  end

  assign prdata    = hit ? APB_DW'(cap_q) : '0;
  assign cap_eff_o = eff_q;

endmodule

// ===== sv/brbuf_ctrl.sv =====
module brbuf_ctrl #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  brbuf_pkg::in_word_t          word_i,
  input  logic                         clear_i,
  input  logic [$clog2(DEPTH):0]       cap_i,
  output logic                         ram_we_o,
  output logic [$clog2(DEPTH)-1:0]     ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic                         ram_re_o,
  output logic [$clog2(DEPTH)-1:0]     ram_raddr_o,
  output brbuf_pkg::res_info_t         info_o
);

  import brbuf_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CntW = AW + 1;

  logic [AW-1:0]   head_q, head_d, head_inc;
  logic [CntW-1:0] count_q, count_d, slot_sum;
  logic [AW-1:0]   slot;
  logic            full, empty, do_write, do_evict, do_read;
  cmd_e            cmd;

  assign cmd   = cmd_e'(word_i.cmd);
  assign full  = (count_q == cap_i);
  assign empty = (count_q == '0);

  // Wrap at the configured capacity, not at the storage depth
  assign head_inc = ((CntW'(head_q) + CntW'(1)) == cap_i) ? '0 : head_q + AW'(1);
  assign slot_sum = CntW'(head_q) + count_q;
  assign slot     = (slot_sum >= cap_i) ? AW'(slot_sum - cap_i) : AW'(slot_sum);

  always_comb begin
    do_read  = 1'b0;
    do_write = 1'b0;
    do_evict = 1'b0;
    head_d   = head_q;
    count_d  = count_q;
    unique case (cmd)
      CMD_READ: begin
        if (!empty) begin
          do_read = 1'b1;
          head_d  = head_inc;
          count_d = count_q - CntW'(1);
        end
      end
      CMD_WRITE, CMD_OVERWRITE: begin
        if (!full) begin
          do_write = 1'b1;
          count_d  = count_q + CntW'(1);
        end else if (cmd == CMD_OVERWRITE) begin
          do_evict = 1'b1;
          head_d   = head_inc;
        end
      end
      CMD_FLUSH: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
        head_d  = head_q;
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (clear_i) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (take_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Eviction reads the head and overwrites it in the same cycle (read-first store)
  assign ram_we_o    = take_i & (do_write | do_evict);
  assign ram_waddr_o = do_evict ? head_q : slot;
  assign ram_wdata_o = word_i.data_in;
  assign ram_re_o    = take_i & (do_read | do_evict);
  assign ram_raddr_o = head_q;

  always_comb begin
    info_o.rd    = do_read | do_evict;
    info_o.acc   = do_read | do_write | do_evict;
    info_o.level = CAP_W'(count_d);
    if (count_d == '0) begin
      info_o.status = FILL_EMPTY;
    end else if (count_d < cap_i) begin
      info_o.status = FILL_PARTIAL;
    end else begin
      info_o.status = FILL_FULL;
    end
  end

endmodule

// ===== sv/byte_ring_buffer_with_overwrite.sv =====
// Channel | Dir | Handshake                 | Word
// in      | in  | in_valid_i / in_ready_o   | in_word_i   (cmd, data_in)
// out     | out | out_valid_o / out_ready_i | out_word_o  (data_out, status, fill)
// apb     | in  | psel, penable, pwrite     | paddr, pwdata -> prdata (capacity)
//
// Throughput: one word per cycle while the output is not stalled. An accepted
// word passes through the read stage, which waits for the registered read
// data of the byte store, and then into the output register.
// Reset: pointer and fill count clear at once; the byte store is not cleared.
// A stalled output holds the result register and the word behind it in the
// read stage; input stalls only when both are occupied.
module byte_ring_buffer_with_overwrite #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  brbuf_pkg::in_word_t           in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output brbuf_pkg::out_word_t          out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brbuf_pkg::APB_AW-1:0]  paddr,
  input  logic [brbuf_pkg::APB_DW-1:0]  pwdata,
  output logic [brbuf_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);

  import brbuf_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CntW = AW + 1;

  logic [CntW-1:0] cap_eff;
  logic            cfg_wr;
  logic            take;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;
  res_info_t       info;

  // Read stage: result info waiting for the store data
  logic            s1_valid_q;
  res_info_t       s1_info_q;
  logic            s1_pend_q;
  logic [7:0]      s1_byte_q;
  logic [7:0]      s1_data;
  logic            advance;

  // Output register
  logic            out_valid_q;
  out_word_t       out_q;

  brbuf_cfg #(
    .DEPTH (DEPTH)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_wr_o  (cfg_wr),
    .cap_eff_o (cap_eff)
  );

  brbuf_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .word_i      (in_word_i),
    .clear_i     (cfg_wr),
    .cap_i       (cap_eff),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .info_o      (info)
  );

  brbuf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Move the read stage forward whenever the output register frees up
  assign advance    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;
  assign take       = in_valid_i & in_ready_o;

  // Store data is live only in the cycle after the read; keep a copy if stalled
  assign s1_data = s1_pend_q ? ram_rdata : s1_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        s1_valid_q <= 1'b1;
        s1_pend_q  <= info.rd;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
        s1_pend_q  <= 1'b0;
      end else begin
        s1_pend_q  <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_info_q <= info;
    end
    if (!take) begin
      s1_byte_q <= s1_data;
    end
    if (advance) begin
      out_q.data_out       <= s1_info_q.rd ? s1_data : 8'd0;
      out_q.data_out_valid <= s1_info_q.rd;
      out_q.accepted       <= s1_info_q.acc;
      out_q.fill_level     <= s1_info_q.level;
      out_q.fill_status    <= s1_info_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_evict_is_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.data_out_valid || out_q.accepted))
    else $error("byte shown without an accepted command");

  a_empty_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.fill_status == FILL_EMPTY) == (out_q.fill_level == '0)))
    else $error("empty status and fill level disagree");

  a_level_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (CntW'(s1_info_q.level) <= cap_eff))
    else $error("fill level above capacity");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && !s1_pend_q))
    else $error("read stage lost while stalled");

  a_store_only_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we || ram_re) |-> take)
    else $error("store access without an accepted word");
`endif

endmodule
